@@ rtl/osp_pkg.sv @@
// Shared types, widths and codes for the one-shot pulse channel controller.
package osp_pkg;

  // Fixed field widths
  localparam int CHAN_W     = 3;
  localparam int DUR_W      = 16;
  localparam int VIEW_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Item kinds on the func field
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_FIRE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARMED_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIRED_MASK         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_PRESENT_MASK = 2'd2;

  // Fire request status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_ENABLED  = 3'd1,
    ST_BAD_CHANNEL  = 3'd2,
    ST_BAD_DURATION = 3'd3,
    ST_UNWIRED      = 3'd4,
    ST_ALREADY      = 3'd5
  } status_t;

  // Update command from the top level into the channel bank
  typedef struct packed {
    logic              tick;
    logic              fire;
    logic [CHAN_W-1:0] channel;
    logic [DUR_W-1:0]  duration_ms;
  } bank_cmd_t;

  // Per-channel view of the low channels as seen in the result fields
  typedef struct packed {
    logic [VIEW_W-1:0] pulse;
    logic [VIEW_W-1:0] fired;
  } bank_view_t;

endpackage

@@ rtl/osp_stream_if.sv @@
// Request and result channel interfaces with valid/ready handshake.
interface osp_req_if;
  import osp_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAN_W-1:0] channel;
  logic [DUR_W-1:0]  duration_ms;
  logic [VIEW_W-1:0] sense_levels;

  modport source(output valid, func, channel, duration_ms, sense_levels, input ready);
  modport sink(input valid, func, channel, duration_ms, sense_levels, output ready);
endinterface

interface osp_res_if;
  import osp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VIEW_W-1:0]   pulse_out;
  logic [VIEW_W-1:0]   fired_flags;
  logic [VIEW_W-1:0]   continuity;

  modport source(output valid, status, pulse_out, fired_flags, continuity, input ready);
  modport sink(input valid, status, pulse_out, fired_flags, continuity, output ready);
endinterface

@@ rtl/osp_fire_check.sv @@
// Ordered interlock checks for a fire request, giving the first failing status.
module osp_fire_check #(
  parameter int NUM_CHANNELS    = 4,
  parameter int MAX_PULSE_TICKS = 30000
) (
  input  logic                        armed_enable,
  input  logic [osp_pkg::VIEW_W-1:0]  wired_mask,
  input  logic [osp_pkg::CHAN_W-1:0]  channel,
  input  logic [osp_pkg::DUR_W-1:0]   duration_ms,
  input  osp_pkg::bank_view_t         view,
  output osp_pkg::status_t            status
);
  import osp_pkg::*;

  localparam logic [CHAN_W:0]  NUM_L = (CHAN_W + 1)'(NUM_CHANNELS);
  localparam logic [DUR_W-1:0] MAX_L = DUR_W'(MAX_PULSE_TICKS);

  logic [1:0] low_ch;
  logic       low_range;

  assign low_ch    = channel[1:0];
  assign low_range = (channel[CHAN_W-1] == 1'b0);

  // Checks in fixed order; the first one that fails decides
  always_comb begin
    priority if (!armed_enable) begin
      status = ST_NOT_ENABLED;
    end else if ({1'b0, channel} >= NUM_L) begin
      status = ST_BAD_CHANNEL;
    end else if (duration_ms == '0 || duration_ms > MAX_L) begin
      status = ST_BAD_DURATION;
    end else if (!low_range || !wired_mask[low_ch]) begin
      status = ST_UNWIRED;
    end else if (view.fired[low_ch]) begin
      status = ST_ALREADY;
    end else begin
      status = ST_OK;
    end
  end

endmodule

@@ rtl/osp_channel_bank.sv @@
// Per-channel fired flags and pulse countdown counters.
module osp_channel_bank #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  osp_pkg::bank_cmd_t  cmd,
  output osp_pkg::bank_view_t view,
  output osp_pkg::bank_view_t view_next
);
  import osp_pkg::*;

  logic [DUR_W-1:0] ticks_left      [NUM_CHANNELS];
  logic [DUR_W-1:0] ticks_left_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] has_fired;
  logic [NUM_CHANNELS-1:0] has_fired_next;

  // Load on an accepted fire, count down on a tick
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ticks_left_next[i] = ticks_left[i];
      has_fired_next[i]  = has_fired[i];
      if (cmd.fire && cmd.channel == CHAN_W'(i)) begin
        ticks_left_next[i] = cmd.duration_ms;
        has_fired_next[i]  = 1'b1;
      end else if (cmd.tick && ticks_left[i] != '0) begin
        ticks_left_next[i] = ticks_left[i] - DUR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ticks_left[i] <= '0;
      end
      has_fired <= '0;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ticks_left[i] <= ticks_left_next[i];
      end
      has_fired <= has_fired_next;
    end
  end

  // Views of the low channels; missing channels read as zero
  always_comb begin
    view      = '0;
    view_next = '0;
    for (int j = 0; j < VIEW_W; j++) begin
      if (j < NUM_CHANNELS) begin
        view.pulse[j]      = (ticks_left[j] != '0);
        view.fired[j]      = has_fired[j];
        view_next.pulse[j] = (ticks_left_next[j] != '0);
        view_next.fired[j] = has_fired_next[j];
      end
    end
  end

endmodule

@@ rtl/oneshot_pulse_channels.sv @@
// Top level of the one-shot pulse channel controller.
//
// Usage: each request on req is either a millisecond tick (func = 0) or a
// fire request (func = 1) naming a channel and a duration in ticks. Every
// request gives exactly one result on res: the status of the fire checks
// (always ok for a tick) and the output, fired and continuity bits after
// the request's update.
// Latency: the result is valid in the cycle after the request is taken.
// Throughput: one request per cycle; the state update and the result are
// one pass of per-channel logic between the request and the result register.
// The result register decouples the sides: req.ready is high while the
// register is empty or being drained, so a stalled receiver holds the
// result and back-pressures the sender after one request.
// The user must write configuration (wr_en/wr_index/wr_data) only while the
// block idles, which is not enforced: index 0 armed_enable, 1 wired_mask,
// 2 sense_present_mask; others ignored. Reset: clears the registers, all
// fired flags, counters and the result register; a channel can fire once between resets.
module oneshot_pulse_channels #(
  parameter int NUM_CHANNELS    = 4,
  parameter int MAX_PULSE_TICKS = 30000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [osp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [osp_pkg::CFG_DATA_W-1:0] wr_data,
  osp_req_if.sink                       req,
  osp_res_if.source                     res
);
  import osp_pkg::*;

  localparam logic [VIEW_W-1:0] VIEW_MASK =
    (NUM_CHANNELS >= VIEW_W) ? {VIEW_W{1'b1}} : VIEW_W'((1 << NUM_CHANNELS) - 1);

  logic              armed_enable;
  logic [VIEW_W-1:0] wired_mask;
  logic [VIEW_W-1:0] sense_present_mask;

  logic       accept;
  status_t    fire_status;
  bank_cmd_t  cmd;
  bank_view_t view;
  bank_view_t view_next;

  logic                res_valid;
  logic [STATUS_W-1:0] status;
  logic [VIEW_W-1:0]   pulse_out;
  logic [VIEW_W-1:0]   fired_flags;
  logic [VIEW_W-1:0]   continuity;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_enable       <= 1'b0;
      wired_mask         <= '0;
      sense_present_mask <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ARMED_ENABLE:       armed_enable       <= wr_data[0];
        REG_WIRED_MASK:         wired_mask         <= wr_data;
        REG_SENSE_PRESENT_MASK: sense_present_mask <= wr_data;
        default: ;
      endcase
    end
  end

  // Request handshake
  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;

  osp_fire_check #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .MAX_PULSE_TICKS(MAX_PULSE_TICKS)
  ) u_check (
    .armed_enable(armed_enable),
    .wired_mask  (wired_mask),
    .channel     (req.channel),
    .duration_ms (req.duration_ms),
    .view        (view),
    .status      (fire_status)
  );

  // Update command for the channel bank
  always_comb begin
    cmd.tick        = accept && (req.func == FUNC_TICK);
    cmd.fire        = accept && (req.func == FUNC_FIRE) && (fire_status == ST_OK);
    cmd.channel     = req.channel;
    cmd.duration_ms = req.duration_ms;
  end

  osp_channel_bank #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_bank (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .view     (view),
    .view_next(view_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req.ready) begin
      res_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= (req.func == FUNC_FIRE) ? fire_status : ST_OK;
      pulse_out   <= view_next.pulse;
      fired_flags <= view_next.fired;
      continuity  <= VIEW_MASK & ((sense_present_mask & req.sense_levels) |
                                  (~sense_present_mask & ~view_next.fired));
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = status;
  assign res.pulse_out   = pulse_out;
  assign res.fired_flags = fired_flags;
  assign res.continuity  = continuity;

endmodule

@@ rtl/osp_checker.sv @@
// Port-level assertions for the one-shot pulse controller, bound to the top.
module osp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_func,
  input logic [osp_pkg::DUR_W-1:0]     in_duration_ms,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [osp_pkg::STATUS_W-1:0]  out_status,
  input logic [osp_pkg::VIEW_W-1:0]    out_pulse_out,
  input logic [osp_pkg::VIEW_W-1:0]    out_fired_flags
);
  import osp_pkg::*;

  // A stalled result stays valid
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Every accepted request shows a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted request");

  // A tick always reports ok
  a_tick_ok: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == FUNC_TICK |=> out_status == ST_OK)
    else $error("tick reported a failure status");

  // A zero-length fire is never accepted
  a_zero_dur: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == FUNC_FIRE && in_duration_ms == '0
    |=> out_status != ST_OK)
    else $error("zero duration fire accepted");

  // A running output belongs to a fired channel
  a_pulse_fired: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pulse_out & ~out_fired_flags) == '0)
    else $error("pulse on a channel that never fired");

endmodule

bind oneshot_pulse_channels osp_checker u_osp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .in_func        (req.func),
  .in_duration_ms (req.duration_ms),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .out_status     (res.status),
  .out_pulse_out  (res.pulse_out),
  .out_fired_flags(res.fired_flags)
);

@@ tb/oneshot_pulse_channels_tb.sv @@
// Self-checking testbench for the one-shot pulse channel controller.
module oneshot_pulse_channels_tb;
  import osp_pkg::*;

  localparam int NUM_CH       = 4;
  localparam int MAX_TICKS    = 30000;
  localparam int HOLD_CYCLES  = 60;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 110;
  localparam int DIR_N        = 27;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;

  // Index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 2'd3;

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] channel;
    logic [DUR_W-1:0]  duration_ms;
    logic [VIEW_W-1:0] sense_levels;
  } pulse_req_t;

  typedef struct packed {
    status_t           status;
    logic [VIEW_W-1:0] pulse_out;
    logic [VIEW_W-1:0] fired_flags;
    logic [VIEW_W-1:0] continuity;
  } pulse_result_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pulse_req_t            req;
    logic                  typed;
    pulse_result_t         want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  osp_req_if req_ch();
  osp_res_if res_ch();

  oneshot_pulse_channels #(
    .NUM_CHANNELS(NUM_CH),
    .MAX_PULSE_TICKS(MAX_TICKS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .req(req_ch),
    .res(res_ch)
  );

  // Predictor copy of the configuration and channel state
  logic              armed_q  = 1'b0;
  logic [3:0]        wired_q  = '0;
  logic [3:0]        sense_q  = '0;
  logic [3:0]        fired_q  = '0;
  logic [DUR_W-1:0]  ticks_q [NUM_CH] = '{default: '0};

  pulse_result_t due_results [$];
  stim_row_t     dir_rows [DIR_N];
  int            idle_pct   = 28;
  bit            hold_off   = 1'b0;
  int            mismatches = 0;
  int            cycles     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the channel state and return the result it gives
  function automatic pulse_result_t predict_pulse(input pulse_req_t r);
    pulse_result_t o;
    logic [1:0]    ch;
    ch = r.channel[1:0];
    o = '0;
    o.status = ST_OK;
    if (r.func == FUNC_FIRE) begin
      if (!armed_q) o.status = ST_NOT_ENABLED;
      else if (r.channel >= NUM_CH) o.status = ST_BAD_CHANNEL;
      else if (r.duration_ms == '0 || r.duration_ms > MAX_TICKS) o.status = ST_BAD_DURATION;
      else if (!wired_q[ch]) o.status = ST_UNWIRED;
      else if (fired_q[ch]) o.status = ST_ALREADY;
      else begin
        fired_q[ch] = 1'b1;
        ticks_q[ch] = r.duration_ms;
      end
    end else begin
      for (int i = 0; i < NUM_CH; i++)
        if (ticks_q[i] != '0) ticks_q[i] = ticks_q[i] - 1'b1;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      o.pulse_out[i]   = (ticks_q[i] != '0);
      o.fired_flags[i] = fired_q[i];
      o.continuity[i]  = sense_q[i] ? r.sense_levels[i] : ~fired_q[i];
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Register write, only once every pending result is back; entered at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_ARMED_ENABLE:       armed_q = data[0];
      REG_WIRED_MASK:         wired_q = data;
      REG_SENSE_PRESENT_MASK: sense_q = data;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one request with random idle cycles ahead of it; entered at a falling edge
  task automatic drive_req(input pulse_req_t r, input logic typed, input pulse_result_t given);
    pulse_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= r.func;
    req_ch.channel      <= r.channel;
    req_ch.duration_ms  <= r.duration_ms;
    req_ch.sense_levels <= r.sense_levels;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    want = predict_pulse(r);
    if (typed) want = given;
    due_results.push_back(want);
    @(negedge clk);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    pulse_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d pulse %h fired %h cont %h",
                 $time, res_ch.status, res_ch.pulse_out, res_ch.fired_flags, res_ch.continuity);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 4'(want.status), 4'(res_ch.status));
        check_field("pulse_out", want.pulse_out, res_ch.pulse_out);
        check_field("fired_flags", want.fired_flags, res_ch.fired_flags);
        check_field("continuity", want.continuity, res_ch.continuity);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Request sender and configuration
  initial begin
    pulse_req_t r;
    int         k;
    int         p;

    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= '0;
    wr_data             <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.func         <= FUNC_TICK;
    req_ch.channel      <= '0;
    req_ch.duration_ms  <= '0;
    req_ch.sense_levels <= '0;

    // Directed rows: error codes in check order, first fire, refire, running pulse,
    // enable cleared while running, sense inputs, unlisted register index
    dir_rows = '{
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_TICK, 3'd0, 16'd0, 4'hF}, 1'b1, '{ST_OK, 4'h0, 4'h0, 4'hF}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd0, 16'd100, 4'h0}, 1'b1,
        '{ST_NOT_ENABLED, 4'h0, 4'h0, 4'hF}},
      '{ROW_CFG, REG_ARMED_ENABLE, 4'd1, '0, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd4, 16'd10, 4'h0}, 1'b1,
        '{ST_BAD_CHANNEL, 4'h0, 4'h0, 4'hF}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd7, 16'd10, 4'hF}, 1'b1,
        '{ST_BAD_CHANNEL, 4'h0, 4'h0, 4'hF}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd0, 16'd0, 4'h0}, 1'b1,
        '{ST_BAD_DURATION, 4'h0, 4'h0, 4'hF}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd1, 16'd30001, 4'h0}, 1'b1,
        '{ST_BAD_DURATION, 4'h0, 4'h0, 4'hF}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd2, 16'hFFFF, 4'h0}, 1'b1,
        '{ST_BAD_DURATION, 4'h0, 4'h0, 4'hF}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd3, 16'd30000, 4'h0}, 1'b1,
        '{ST_UNWIRED, 4'h0, 4'h0, 4'hF}},
      '{ROW_CFG, REG_WIRED_MASK, 4'hF, '0, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd0, 16'd1, 4'h0}, 1'b1, '{ST_OK, 4'h1, 4'h1, 4'hE}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd0, 16'd5, 4'h0}, 1'b1,
        '{ST_ALREADY, 4'h1, 4'h1, 4'hE}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_TICK, 3'd0, 16'd0, 4'h0}, 1'b1, '{ST_OK, 4'h0, 4'h1, 4'hE}},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd3, 16'd30000, 4'h0}, 1'b1,
        '{ST_OK, 4'h8, 4'h9, 4'h6}},
      '{ROW_CFG, REG_ARMED_ENABLE, 4'd0, '0, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_TICK, 3'd7, 16'hFFFF, 4'h0}, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd1, 16'd2, 4'h0}, 1'b0, '0},
      '{ROW_CFG, REG_SENSE_PRESENT_MASK, 4'hF, '0, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_TICK, 3'd0, 16'd0, 4'h5}, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_TICK, 3'd0, 16'd0, 4'hA}, 1'b0, '0},
      '{ROW_CFG, REG_UNLISTED, 4'hF, '0, 1'b0, '0},
      '{ROW_CFG, REG_SENSE_PRESENT_MASK, 4'h5, '0, 1'b0, '0},
      '{ROW_CFG, REG_ARMED_ENABLE, 4'd1, '0, 1'b0, '0},
      '{ROW_CFG, REG_WIRED_MASK, 4'h9, '0, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd0, 16'd3, 4'hF}, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_FIRE, 3'd1, 16'd3, 4'hF}, 1'b0, '0},
      '{ROW_REQ, 2'd0, 4'd0, '{FUNC_TICK, 3'd5, 16'd9, 4'h0}, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_N; k++) begin
      if (dir_rows[k].kind == ROW_CFG) write_reg(dir_rows[k].idx, dir_rows[k].data);
      else drive_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases, each under its own register setting
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_ARMED_ENABLE, 4'd1);
          write_reg(REG_WIRED_MASK, 4'hF);
          write_reg(REG_SENSE_PRESENT_MASK, 4'h0);
        end
        1: begin
          write_reg(REG_ARMED_ENABLE, 4'd1);
          write_reg(REG_WIRED_MASK, 4'($urandom_range(15)));
          write_reg(REG_SENSE_PRESENT_MASK, 4'hF);
        end
        2: begin
          write_reg(REG_ARMED_ENABLE, 4'd0);
          write_reg(REG_WIRED_MASK, 4'h0);
          write_reg(REG_SENSE_PRESENT_MASK, 4'($urandom_range(15)));
        end
        3: begin
          write_reg(REG_ARMED_ENABLE, 4'd1);
          write_reg(REG_WIRED_MASK, 4'($urandom_range(15)));
          write_reg(REG_SENSE_PRESENT_MASK, 4'($urandom_range(15)));
        end
        default: begin
          write_reg(REG_ARMED_ENABLE, 4'd1);
          write_reg(REG_WIRED_MASK, 4'hF);
          write_reg(REG_SENSE_PRESENT_MASK, 4'($urandom_range(15)));
        end
      endcase
      // Phase 1 runs with no idling; phase 2 starts with a long receiver hold-off
      if (p == 1) idle_pct = 0;
      if (p == 2) hold_off = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) drain_results();
        r.func    = ($urandom_range(99) < 60) ? FUNC_TICK : FUNC_FIRE;
        r.channel = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
        case ($urandom_range(9))
          0:       r.duration_ms = '0;
          1:       r.duration_ms = 16'($urandom_range(MAX_TICKS + 10, MAX_TICKS - 10));
          2:       r.duration_ms = 16'($urandom);
          default: r.duration_ms = 16'($urandom_range(20, 1));
        endcase
        r.sense_levels = 4'($urandom);
        drive_req(r, 1'b0, '0);
      end
      idle_pct = 28;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
